// File: rtl/core/cthc_pkg.sv
// ----------------------------------------------------------------------------
// cthc_pkg
// Shared widths, constants, codes and helper functions of the complex to
// HSV color unit: CORDIC angle table, log2 steps and hue sector split.
// ----------------------------------------------------------------------------
package cthc_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int PHASE_WIDTH    = 24;
  localparam int BOUND_WIDTH    = 15;
  localparam int CHAN_WIDTH     = 8;
  localparam int ANGLE_STEPS    = 16;
  localparam int MAX_STEPS      = 24;

  localparam logic [CHAN_WIDTH-1:0] GREY_LEVEL = 8'd24;

  typedef enum logic {
    REG_AMP_LOW  = 1'b0,
    REG_AMP_HIGH = 1'b1
  } cfg_reg_t;

  // cordic datapath
  localparam int PRESCALE_SHIFT = 6;
  localparam int XW = ((SAMPLE_WIDTH > PHASE_WIDTH) ? SAMPLE_WIDTH : PHASE_WIDTH)
                      + PRESCALE_SHIFT + 3;
  localparam int ZW             = 27;
  localparam int HALF_TURN_FINE = 11796480;
  localparam int FINE_SHIFT     = 10;
  localparam int ZR_W           = ZW - FINE_SHIFT;
  localparam int ATAN_FINE [MAX_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // magnitude scaling by the inverse cordic gain
  localparam longint INV_GAIN   = 64'd652032874;
  localparam int     GAIN_SPLIT = 15;
  localparam int     GAIN_W     = 15;
  localparam logic [GAIN_W-1:0] GAIN_LO = GAIN_W'(INV_GAIN % (64'd1 << GAIN_SPLIT));
  localparam logic [GAIN_W-1:0] GAIN_HI = GAIN_W'(INV_GAIN >> GAIN_SPLIT);
  localparam int PP_W       = XW - 1 + GAIN_W;
  localparam int MAG_SHIFT  = 36;
  localparam int SUMW       = XW - 1 + GAIN_SPLIT + GAIN_W + 1;
  localparam int MAGW       = SUMW - MAG_SHIFT;

  // hue wrap
  localparam int FULL_TURN   = 23040;
  localparam int SIXTH_TURN  = 3840;
  localparam int HUE_W       = 15;
  localparam int FR_W        = 12;
  localparam int BU_W        = PHASE_WIDTH + 1;
  localparam int HUE_OFFSET  = 365 * FULL_TURN;
  localparam int HUE_SHIFT   = 9;
  localparam int HUE_ODD     = FULL_TURN >> HUE_SHIFT;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = (1 << RECIP_SHIFT) / HUE_ODD;
  localparam int T_W         = BU_W - HUE_SHIFT;
  localparam int BPROD_W     = T_W + RECIP_SHIFT;
  localparam int Q_W         = 11;
  localparam int R_W         = 16;
  localparam int APOS_W      = SAMPLE_WIDTH - 1;

  // log2 fixed point
  localparam int LOG_FRAC = 24;
  localparam int LOG_MW   = 31;
  localparam int LOG_PW   = 4;
  localparam int LOG_W    = LOG_PW + LOG_FRAC;
  localparam int CNT_W    = $clog2(LOG_FRAC);

  // channel division
  localparam int NW = LOG_W + FR_W + 10;
  localparam int QW = CHAN_WIDTH;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } hue_sector_t;

  typedef enum logic [1:0] {
    LOG_START,
    LOG_RUN,
    LOG_DONE
  } blog_state_t;

  typedef struct packed {
    logic [LOG_PW-1:0] p;
    logic [LOG_MW-1:0] m;
  } log_norm_t;

  typedef struct packed {
    logic [LOG_MW-1:0] m;
    logic              b;
  } log_step_t;

  typedef struct packed {
    hue_sector_t       sector;
    logic [FR_W-1:0]   frac;
  } hue_split_t;

  function automatic log_norm_t log_norm(input logic [BOUND_WIDTH-1:0] u);
    log_norm_t res;
    res.p = '0;
    for (int i = 1; i < BOUND_WIDTH; i++) begin
      if (u[i]) res.p = LOG_PW'(i);
    end
    res.m = LOG_MW'({{(LOG_MW-BOUND_WIDTH){1'b0}}, u} << (LOG_MW - 1 - int'(res.p)));
    return res;
  endfunction

  function automatic log_step_t log_step(input logic [LOG_MW-1:0] m);
    log_step_t             res;
    logic [2*LOG_MW-1:0]   sq;
    logic [LOG_MW:0]       m2;
    sq = (2*LOG_MW)'(m) * (2*LOG_MW)'(m);
    m2 = sq[2*LOG_MW-1:LOG_MW-1];
    if (m2[LOG_MW]) begin
      res.m = m2[LOG_MW:1];
      res.b = 1'b1;
    end else begin
      res.m = m2[LOG_MW-1:0];
      res.b = 1'b0;
    end
    return res;
  endfunction

  function automatic hue_split_t hue_split(input logic [HUE_W-1:0] h);
    hue_split_t res;
    res.sector = SEC_RED_YELLOW;
    res.frac   = h[FR_W-1:0];
    for (int s = 1; s < 6; s++) begin
      if (h >= HUE_W'(s * SIXTH_TURN)) begin
        res.sector = hue_sector_t'(3'(s));
        res.frac   = FR_W'(h - HUE_W'(s * SIXTH_TURN));
      end
    end
    return res;
  endfunction

  function automatic logic [NW-1:0] times510(input logic [NW-1:0] x);
    return (x << 9) - (x << 1);
  endfunction

  function automatic logic [NW-1:0] times3840(input logic [NW-1:0] x);
    return (x << 12) - (x << 8);
  endfunction

  function automatic logic [NW-1:0] times7680(input logic [NW-1:0] x);
    return (x << 13) - (x << 9);
  endfunction

endpackage

// File: rtl/core/complex_to_hsv_color_unit.sv
// ----------------------------------------------------------------------------
// complex_to_hsv_color_unit
// Maps one complex sample per transaction to one RGB pixel: hue from phase,
// full saturation, value from the log of the amplitude between two bounds.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with command, sample_valid, operand_a
//   and operand_b. output channel: out_valid / out_stall with red, green,
//   blue. a transaction moves at a clock edge with valid high and stall low.
//   cfg_write with cfg_index and cfg_data sets the low and high amplitude
//   bounds; write them only while no transaction is in flight.
//   throughput: one transaction per clock while in_stall is low. a pixel
//   shows on the output once its sample has passed the 16 cordic stages,
//   the 24 log2 squaring stages and the 8 stage channel divider.
//   after reset and after every bound write the log2 of both bounds is
//   worked out by one shared squarer; in_stall is high meanwhile.
//   when out_stall holds a pixel, the pipeline freezes; an empty input stage
//   still takes one more sample, then in_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
module complex_to_hsv_color_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic                                     cfg_index,
  input  logic [cthc_pkg::BOUND_WIDTH-1:0]         cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     command,
  input  logic                                     sample_valid,
  input  logic signed [cthc_pkg::SAMPLE_WIDTH-1:0] operand_a,
  input  logic signed [cthc_pkg::PHASE_WIDTH-1:0]  operand_b,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [cthc_pkg::CHAN_WIDTH-1:0]          red,
  output logic [cthc_pkg::CHAN_WIDTH-1:0]          green,
  output logic [cthc_pkg::CHAN_WIDTH-1:0]          blue
);
  import cthc_pkg::*;

  // configuration
  logic [BOUND_WIDTH-1:0] amp_low;
  logic [BOUND_WIDTH-1:0] amp_high;
  logic [BOUND_WIDTH-1:0] lo_eff;
  logic                   bounds_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_low  <= BOUND_WIDTH'(1638);
      amp_high <= BOUND_WIDTH'(9830);
    end else if (cfg_write) begin
      if (cfg_index == REG_AMP_LOW) amp_low <= cfg_data;
      if (cfg_index == REG_AMP_HIGH) amp_high <= cfg_data;
    end
  end

  assign lo_eff    = (amp_low == '0) ? BOUND_WIDTH'(1) : amp_low;
  assign bounds_ok = amp_high > lo_eff;

  // log2 of the bounds, one shared squarer
  blog_state_t           blog_state;
  blog_state_t           blog_state_next;
  logic                  blog_busy;
  logic                  blog_load_lo;
  logic                  blog_run;
  logic                  blog_last;
  logic                  blog_sel;
  logic [CNT_W-1:0]      blog_cnt;
  logic [LOG_MW-1:0]     blog_m;
  logic [LOG_PW-1:0]     blog_p;
  logic [LOG_FRAC-1:0]   blog_frac;
  logic [LOG_FRAC-1:0]   blog_frac_next;
  logic [BOUND_WIDTH-1:0] blog_src;
  log_norm_t             blog_norm;
  log_step_t             blog_step;
  logic [LOG_W-1:0]      llo;
  logic [LOG_W-1:0]      lhi;

  always_ff @(posedge clk) begin
    if (rst) blog_state <= LOG_START;
    else blog_state <= blog_state_next;
  end

  always_comb begin
    blog_state_next = blog_state;
    case (blog_state)
      LOG_START: blog_state_next = LOG_RUN;
      LOG_RUN: begin
        if (blog_last && blog_sel) blog_state_next = LOG_DONE;
      end
      LOG_DONE: blog_state_next = LOG_DONE;
      default: blog_state_next = LOG_START;
    endcase
    if (cfg_write) blog_state_next = LOG_START;
  end

  always_comb begin
    blog_busy    = 1'b1;
    blog_load_lo = 1'b0;
    blog_run     = 1'b0;
    case (blog_state)
      LOG_START: blog_load_lo = 1'b1;
      LOG_RUN:   blog_run = 1'b1;
      LOG_DONE:  blog_busy = 1'b0;
      default:   blog_load_lo = 1'b1;
    endcase
  end

  assign blog_last      = blog_cnt == CNT_W'(LOG_FRAC - 1);
  assign blog_src       = blog_load_lo ? lo_eff : amp_high;
  assign blog_norm      = log_norm(blog_src);
  assign blog_step      = log_step(blog_m);
  assign blog_frac_next = {blog_frac[LOG_FRAC-2:0], blog_step.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      blog_sel <= 1'b0;
      blog_cnt <= '0;
    end else if (blog_load_lo) begin
      blog_sel <= 1'b0;
      blog_cnt <= '0;
    end else if (blog_run) begin
      if (blog_last) begin
        blog_sel <= 1'b1;
        blog_cnt <= '0;
      end else begin
        blog_cnt <= blog_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blog_load_lo) begin
      blog_m    <= blog_norm.m;
      blog_p    <= blog_norm.p;
      blog_frac <= '0;
    end else if (blog_run) begin
      if (blog_last) begin
        if (!blog_sel) begin
          llo       <= {blog_p, blog_frac_next};
          blog_m    <= blog_norm.m;
          blog_p    <= blog_norm.p;
          blog_frac <= '0;
        end else begin
          lhi <= {blog_p, blog_frac_next};
        end
      end else begin
        blog_m    <= blog_step.m;
        blog_frac <= blog_frac_next;
      end
    end
  end

  // handshake
  logic                           v0;
  logic                           adv;
  logic                           s0_en;
  logic                           accept;

  assign adv      = !out_valid || !out_stall;
  assign s0_en    = adv || !v0;
  assign in_stall = blog_busy || cfg_write || !s0_en;
  assign accept   = in_valid && !in_stall;

  // input stage
  logic                           s0_cmd;
  logic                           s0_sv;
  logic signed [SAMPLE_WIDTH-1:0] s0_a;
  logic signed [PHASE_WIDTH-1:0]  s0_b;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (s0_en) v0 <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_cmd <= command;
      s0_sv  <= sample_valid;
      s0_a   <= operand_a;
      s0_b   <= operand_b;
    end
  end

  // cordic
  logic                  c_v    [0:ANGLE_STEPS];
  logic signed [XW-1:0]  c_x    [0:ANGLE_STEPS];
  logic signed [XW-1:0]  c_y    [0:ANGLE_STEPS];
  logic signed [ZW-1:0]  c_z    [0:ANGLE_STEPS];
  logic                  c_cmd  [0:ANGLE_STEPS];
  logic                  c_sv   [0:ANGLE_STEPS];
  logic [APOS_W-1:0]     c_apos [0:ANGLE_STEPS];
  logic [BU_W-1:0]       c_bu   [0:ANGLE_STEPS];

  logic signed [XW-1:0]  init_x;
  logic signed [XW-1:0]  init_y;
  logic signed [BU_W:0]  init_bsum;

  assign init_x    = XW'(s0_a) <<< PRESCALE_SHIFT;
  assign init_y    = XW'(s0_b) <<< PRESCALE_SHIFT;
  assign init_bsum = (BU_W+1)'(s0_b) + (BU_W+1)'(HUE_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) c_v[0] <= 1'b0;
    else if (adv) c_v[0] <= v0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (init_x < 0) begin
        c_x[0] <= -init_x;
        c_y[0] <= -init_y;
        c_z[0] <= ZW'(HALF_TURN_FINE);
      end else begin
        c_x[0] <= init_x;
        c_y[0] <= init_y;
        c_z[0] <= '0;
      end
      c_cmd[0]  <= s0_cmd;
      c_sv[0]   <= s0_sv;
      c_apos[0] <= (s0_a > 0) ? s0_a[APOS_W-1:0] : '0;
      c_bu[0]   <= init_bsum[BU_W-1:0];
    end
  end

  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_cordic
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 up;

    assign xs = c_x[k] >>> k;
    assign ys = c_y[k] >>> k;
    assign up = c_y[k] > 0;

    always_ff @(posedge clk) begin
      if (rst) c_v[k+1] <= 1'b0;
      else if (adv) c_v[k+1] <= c_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (up) begin
          c_x[k+1] <= c_x[k] + ys;
          c_y[k+1] <= c_y[k] - xs;
          c_z[k+1] <= c_z[k] + ZW'(ATAN_FINE[k]);
        end else begin
          c_x[k+1] <= c_x[k] - ys;
          c_y[k+1] <= c_y[k] + xs;
          c_z[k+1] <= c_z[k] - ZW'(ATAN_FINE[k]);
        end
        c_cmd[k+1]  <= c_cmd[k];
        c_sv[k+1]   <= c_sv[k];
        c_apos[k+1] <= c_apos[k];
        c_bu[k+1]   <= c_bu[k];
      end
    end
  end

  // magnitude and hue
  logic                   p1_v, p2_v, p3_v, p4_v;
  logic                   p1_cmd, p2_cmd, p3_cmd;
  logic                   p1_sv, p2_sv, p3_sv, p4_sv;
  logic [APOS_W-1:0]      p1_apos, p2_apos, p3_apos;
  logic [BU_W-1:0]        p1_bu, p2_bu;
  logic [PP_W-1:0]        p1_pl, p1_ph;
  logic signed [ZR_W-1:0] p1_zr;
  logic [BPROD_W-1:0]     p1_bprod;
  logic [MAGW-1:0]        p2_mag, p3_mag;
  logic [HUE_W-1:0]       p2_hz, p3_hz;
  logic [Q_W-1:0]         p2_q;
  logic [R_W-1:0]         p3_rb;
  logic [MAGW-1:0]        p4_amp;
  logic [HUE_W-1:0]       p4_hue;

  logic [XW-2:0]          xm;
  logic signed [ZW-1:0]   zsum;
  logic [SUMW-1:0]        msum;
  logic signed [ZR_W-1:0] zsel;
  logic [BU_W-1:0]        qm;
  logic [BU_W-1:0]        rdiff;
  logic [R_W-1:0]         rsub;

  assign xm    = c_x[ANGLE_STEPS][XW-2:0];
  assign zsum  = c_z[ANGLE_STEPS] + ZW'(1 << (FINE_SHIFT - 1));
  assign msum  = (SUMW'(p1_ph) << GAIN_SPLIT) + SUMW'(p1_pl)
               + (SUMW'(1) << (MAG_SHIFT - 1));
  assign zsel  = (p1_zr < 0) ? (p1_zr + ZR_W'(FULL_TURN)) : p1_zr;
  assign qm    = BU_W'(BU_W'(p2_q) * BU_W'(FULL_TURN));
  assign rdiff = p2_bu - qm;
  assign rsub  = p3_rb - R_W'(FULL_TURN);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else if (adv) begin
      p1_v <= c_v[ANGLE_STEPS];
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pl    <= PP_W'(xm) * PP_W'(GAIN_LO);
      p1_ph    <= PP_W'(xm) * PP_W'(GAIN_HI);
      p1_zr    <= zsum[ZW-1:FINE_SHIFT];
      p1_bprod <= BPROD_W'(c_bu[ANGLE_STEPS][BU_W-1:HUE_SHIFT]) * BPROD_W'(RECIP);
      p1_cmd   <= c_cmd[ANGLE_STEPS];
      p1_sv    <= c_sv[ANGLE_STEPS];
      p1_apos  <= c_apos[ANGLE_STEPS];
      p1_bu    <= c_bu[ANGLE_STEPS];

      p2_mag   <= msum[SUMW-1:MAG_SHIFT];
      p2_hz    <= zsel[HUE_W-1:0];
      p2_q     <= p1_bprod[RECIP_SHIFT +: Q_W];
      p2_bu    <= p1_bu;
      p2_cmd   <= p1_cmd;
      p2_sv    <= p1_sv;
      p2_apos  <= p1_apos;

      p3_rb    <= rdiff[R_W-1:0];
      p3_mag   <= p2_mag;
      p3_hz    <= p2_hz;
      p3_cmd   <= p2_cmd;
      p3_sv    <= p2_sv;
      p3_apos  <= p2_apos;

      if (p3_cmd) begin
        p4_amp <= p3_mag;
        p4_hue <= p3_hz;
      end else begin
        p4_amp <= MAGW'(p3_apos);
        p4_hue <= (p3_rb >= R_W'(FULL_TURN)) ? rsub[HUE_W-1:0] : p3_rb[HUE_W-1:0];
      end
      p4_sv <= p3_sv;
    end
  end

  // log2 of the amplitude
  logic                  l_v    [0:LOG_FRAC];
  logic [LOG_MW-1:0]     l_m    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]   l_frac [0:LOG_FRAC];
  logic [LOG_PW-1:0]     l_p    [0:LOG_FRAC];
  logic [MAGW-1:0]       l_amp  [0:LOG_FRAC];
  hue_sector_t           l_sec  [0:LOG_FRAC];
  logic [FR_W-1:0]       l_fr   [0:LOG_FRAC];
  logic                  l_sv   [0:LOG_FRAC];

  logic [BOUND_WIDTH-1:0] l_u;
  log_norm_t              l_norm;
  hue_split_t             l_hs;

  assign l_u    = (p4_amp[MAGW-1:BOUND_WIDTH] == '0) ? p4_amp[BOUND_WIDTH-1:0] : '1;
  assign l_norm = log_norm(l_u);
  assign l_hs   = hue_split(p4_hue);

  always_ff @(posedge clk) begin
    if (rst) l_v[0] <= 1'b0;
    else if (adv) l_v[0] <= p4_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_m[0]    <= l_norm.m;
      l_p[0]    <= l_norm.p;
      l_frac[0] <= '0;
      l_amp[0]  <= p4_amp;
      l_sec[0]  <= l_hs.sector;
      l_fr[0]   <= l_hs.frac;
      l_sv[0]   <= p4_sv;
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    log_step_t st;

    assign st = log_step(l_m[k]);

    always_ff @(posedge clk) begin
      if (rst) l_v[k+1] <= 1'b0;
      else if (adv) l_v[k+1] <= l_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        l_m[k+1]    <= st.m;
        l_frac[k+1] <= {l_frac[k][LOG_FRAC-2:0], st.b};
        l_p[k+1]    <= l_p[k];
        l_amp[k+1]  <= l_amp[k];
        l_sec[k+1]  <= l_sec[k];
        l_fr[k+1]   <= l_fr[k];
        l_sv[k+1]   <= l_sv[k];
      end
    end
  end

  // value fraction and channel operands
  logic              d0_v, d1_v;
  logic              d0_ok, d1_ok;
  hue_sector_t       d0_sec, d1_sec;
  logic [FR_W-1:0]   d0_fr;
  logic [LOG_W-1:0]  d0_num, d0_den;
  logic [NW-1:0]     d1_n0, d1_dv0, d1_numfr, d1_numfl, d1_den;

  logic [LOG_W-1:0]  la;
  logic [LOG_W-1:0]  dd_num;
  logic [LOG_W-1:0]  dd_den;

  assign la = {l_p[LOG_FRAC], l_frac[LOG_FRAC]};

  always_comb begin
    dd_den = lhi - llo;
    if (l_amp[LOG_FRAC] <= MAGW'(lo_eff)) dd_num = '0;
    else if (l_amp[LOG_FRAC] >= MAGW'(amp_high)) dd_num = dd_den;
    else dd_num = la - llo;
    if (dd_den == '0) begin
      dd_den = LOG_W'(1);
      dd_num = (l_amp[LOG_FRAC] >= MAGW'(amp_high)) ? LOG_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
      d1_v <= 1'b0;
    end else if (adv) begin
      d0_v <= l_v[LOG_FRAC];
      d1_v <= d0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_num   <= dd_num;
      d0_den   <= dd_den;
      d0_ok    <= l_sv[LOG_FRAC] && bounds_ok;
      d0_sec   <= l_sec[LOG_FRAC];
      d0_fr    <= l_fr[LOG_FRAC];

      d1_n0    <= times510(NW'(d0_num)) + NW'(d0_den);
      d1_dv0   <= NW'(d0_den) << 1;
      d1_numfr <= NW'(d0_num) * NW'(d0_fr);
      d1_numfl <= NW'(d0_num) * NW'(FR_W'(SIXTH_TURN) - d0_fr);
      d1_den   <= NW'(d0_den);
      d1_ok    <= d0_ok;
      d1_sec   <= d0_sec;
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  logic              dv_v   [0:QW];
  logic              dv_ok  [0:QW];
  hue_sector_t       dv_sec [0:QW];
  logic [NW-1:0]     dv_rem [0:QW][0:2];
  logic [NW-1:0]     dv_div [0:QW][0:2];
  logic [QW-1:0]     dv_q   [0:QW][0:2];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= d1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0][0] <= d1_n0;
      dv_div[0][0] <= d1_dv0;
      dv_rem[0][1] <= times510(d1_numfr) + times3840(d1_den);
      dv_div[0][1] <= times7680(d1_den);
      dv_rem[0][2] <= times510(d1_numfl) + times3840(d1_den);
      dv_div[0][2] <= times7680(d1_den);
      dv_q[0][0]   <= '0;
      dv_q[0][1]   <= '0;
      dv_q[0][2]   <= '0;
      dv_ok[0]     <= d1_ok;
      dv_sec[0]    <= d1_sec;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
    end

    for (genvar n = 0; n < 3; n++) begin : g_lane
      logic [NW-1:0] trial;

      assign trial = dv_div[j][n] << (QW - 1 - j);

      always_ff @(posedge clk) begin
        if (adv) begin
          if (dv_rem[j][n] >= trial) begin
            dv_rem[j+1][n] <= dv_rem[j][n] - trial;
            dv_q[j+1][n]   <= {dv_q[j][n][QW-2:0], 1'b1};
          end else begin
            dv_rem[j+1][n] <= dv_rem[j][n];
            dv_q[j+1][n]   <= {dv_q[j][n][QW-2:0], 1'b0};
          end
          dv_div[j+1][n] <= dv_div[j][n];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ok[j+1]  <= dv_ok[j];
        dv_sec[j+1] <= dv_sec[j];
      end
    end
  end

  // pixel assembly
  logic [CHAN_WIDTH-1:0] top, rise, fall;
  logic [CHAN_WIDTH-1:0] red_next, green_next, blue_next;

  assign top  = dv_q[QW][0];
  assign rise = dv_q[QW][1];
  assign fall = dv_q[QW][2];

  always_comb begin
    red_next   = GREY_LEVEL;
    green_next = GREY_LEVEL;
    blue_next  = GREY_LEVEL;
    if (dv_ok[QW]) begin
      case (dv_sec[QW])
        SEC_RED_YELLOW: begin
          red_next = top; green_next = rise; blue_next = '0;
        end
        SEC_YELLOW_GREEN: begin
          red_next = fall; green_next = top; blue_next = '0;
        end
        SEC_GREEN_CYAN: begin
          red_next = '0; green_next = top; blue_next = rise;
        end
        SEC_CYAN_BLUE: begin
          red_next = '0; green_next = fall; blue_next = top;
        end
        SEC_BLUE_MAGENTA: begin
          red_next = rise; green_next = '0; blue_next = top;
        end
        default: begin
          red_next = top; green_next = '0; blue_next = fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule
